FILE: rtl/core/battery_monitor_command_engine_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the battery monitor command engine
// Each macro checks one property on the rising edge of clk, disabled while
// arst_n is low. Synthesis builds see empty bodies.
// ----------------------------------------------------------------------------
`ifndef BATTERY_MONITOR_COMMAND_ENGINE_UNIT_MACROS_SVH
`define BATTERY_MONITOR_COMMAND_ENGINE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define BMCE_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle property failed");
// Consequent must hold in the cycle after the antecedent.
`define BMCE_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle property failed");
`else
`define BMCE_ASSERT_IMP(label, ante, cons)
`define BMCE_ASSERT_NXT(label, ante, cons)
`endif

`endif

FILE: rtl/core/bmce_pkg.sv
// ----------------------------------------------------------------------------
// bmce_pkg
// Types, sizes, command codes and memory map of the battery monitor command
// engine.
// ----------------------------------------------------------------------------
package bmce_pkg;

	localparam int MEM_BYTES     = 160;
	localparam int SCRATCH_BYTES = 96;
	localparam int PAGE_BYTES    = 32;

	localparam int MAIN_AW = $clog2(MEM_BYTES);
	localparam int SCR_AW  = $clog2(SCRATCH_BYTES);
	localparam int CNT_W   = $clog2(PAGE_BYTES + 1);

	localparam int MEM_READ_START = 3 * PAGE_BYTES;
	localparam int MEM_READ_END   = 5 * PAGE_BYTES;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_NV_BUSY   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TEMP_BUSY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID = 2'd2;

	localparam logic [2:0] FN_BUS_RESET = 3'd0;
	localparam logic [2:0] FN_WRITE     = 3'd1;
	localparam logic [2:0] FN_READ      = 3'd2;
	localparam logic [2:0] FN_TICK      = 3'd3;
	localparam logic [2:0] FN_SET_TEMP  = 3'd4;
	localparam logic [2:0] FN_PRESET    = 3'd5;

	localparam logic [7:0] CMD_RD_SCR  = 8'h11;
	localparam logic [7:0] CMD_WR_SCR  = 8'h17;
	localparam logic [7:0] CMD_COPY1   = 8'h22;
	localparam logic [7:0] CMD_COPY2   = 8'h25;
	localparam logic [7:0] CMD_COPY3   = 8'h28;
	localparam logic [7:0] CMD_RECALL1 = 8'h71;
	localparam logic [7:0] CMD_RECALL2 = 8'h77;
	localparam logic [7:0] CMD_RECALL3 = 8'h7A;
	localparam logic [7:0] CMD_SET_LCK = 8'h43;
	localparam logic [7:0] CMD_CLR_LCK = 8'h44;
	localparam logic [7:0] CMD_TEMP    = 8'hD2;
	localparam logic [7:0] CMD_RD_MEM  = 8'hB2;
	localparam logic [7:0] CMD_INC_CYC = 8'hB5;
	localparam logic [7:0] CMD_CLR_CYC = 8'hB8;
	localparam logic [7:0] CMD_NOP     = 8'h8E;
	localparam logic [7:0] CMD_DATA    = 8'h84;

	localparam logic [7:0] TEMP2_ADDR  = 8'h60;
	localparam logic [7:0] TEMP_ADDR   = 8'h61;
	localparam logic [7:0] STATUS_ADDR = 8'h62;
	localparam logic [7:0] ID_LO_ADDR  = 8'h80;
	localparam logic [7:0] ID_HI_ADDR  = 8'h81;
	localparam logic [7:0] CYC_HI_ADDR = 8'h82;
	localparam logic [7:0] CYC_LO_ADDR = 8'h83;

	localparam int LOCK_BIT = 2;
	localparam logic [7:0] LOCK_MASK = 8'b100;

	localparam logic signed [7:0] TEMP_MAX = 8'sd126;
	localparam logic signed [7:0] TEMP_MIN = -8'sd40;

	typedef enum logic [2:0] {
		PH_CMD    = 3'd0,
		PH_ADDR   = 3'd1,
		PH_RD_SCR = 3'd2,
		PH_WR_SCR = 3'd3,
		PH_RD_MEM = 3'd4,
		PH_DATA   = 3'd5,
		PH_DONE   = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_LOCKCHK,
		ST_COPY,
		ST_RMW,
		ST_WR2,
		ST_RDWAIT,
		ST_FINISH
	} state_t;

	typedef enum logic [2:0] {
		RMW_SET_LOCK,
		RMW_CLR_LOCK,
		RMW_STATUS,
		RMW_INC_LO,
		RMW_INC_HI
	} rmw_op_t;

	typedef struct packed {
		logic [2:0]        func;
		logic [7:0]        data_byte;
		logic signed [7:0] temperature;
		logic [15:0]       cycle_preset;
	} in_item_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic       read_valid;
		logic       command_error;
		logic       temp_requested;
	} out_item_t;

	typedef struct packed {
		logic [15:0] nv_busy_ms;
		logic [15:0] temp_busy_ms;
		logic [15:0] device_id;
	} cfg_t;

	typedef struct packed {
		logic               we;
		logic [MAIN_AW-1:0] waddr;
		logic [7:0]         wdata;
		logic               re;
		logic [MAIN_AW-1:0] raddr;
	} main_req_t;

	typedef struct packed {
		logic              we;
		logic [SCR_AW-1:0] waddr;
		logic [7:0]        wdata;
		logic              re;
		logic [SCR_AW-1:0] raddr;
	} scr_req_t;

endpackage

FILE: rtl/core/battery_monitor_command_engine_unit.sv
// ----------------------------------------------------------------------------
// battery_monitor_command_engine_unit
// Slave-side command engine of a battery monitor memory device, one bus event
// per input beat and one result beat per input beat.
//
//   Channel   Direction  Handshake             Beat contents
//   in        input      in_valid / in_stall   func, data_byte, temperature,
//                                              cycle_preset
//   out       output     out_valid / out_stall read_byte, read_valid,
//                                              command_error, temp_requested
//   cfg       input      cfg_we (no wait)      cfg_index, cfg_data
//
// A simple beat passes EXEC and FINISH between acceptances. A read served from
// a memory passes RDWAIT, a two-byte write WR2 and a read-modify-write RMW; a
// counter increment with carry passes RMW twice. A page copy or recall moves
// one byte per cycle in COPY; a copy of page 1 first passes its lock check.
// Reset needs no clearing pass; per-entry valid bits make unwritten bytes read
// as 0xFF. A stalled result holds the output register, and the engine finishes
// the next result and waits with it until the register frees up.
// ----------------------------------------------------------------------------
module battery_monitor_command_engine_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  bmce_pkg::in_item_t                   in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output bmce_pkg::out_item_t                  out_data,
	input  logic                                 cfg_we,
	input  logic [bmce_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bmce_pkg::CFG_W-1:0]           cfg_data
);

	import bmce_pkg::*;

	// Configuration registers. Writes to an index past the list are dropped.
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.nv_busy_ms   <= 16'd10;
			cfg_q.temp_busy_ms <= 16'd10;
			cfg_q.device_id    <= 16'hFFFF;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NV_BUSY:   cfg_q.nv_busy_ms   <= cfg_data;
				CFG_TEMP_BUSY: cfg_q.temp_busy_ms <= cfg_data;
				CFG_DEVICE_ID: cfg_q.device_id    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// The sequencer talks to the two memories through request structs; read
	// data comes back in the cycle after the request.
	main_req_t   main_req;
	scr_req_t    scr_req;
	logic [7:0]  main_rdata;
	logic [7:0]  scr_rdata;

	logic        res_valid;
	logic        res_take;
	out_item_t   res;

	bmce_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.cfg        (cfg_q),
		.res_valid  (res_valid),
		.res_take   (res_take),
		.res        (res),
		.main_req   (main_req),
		.main_rdata (main_rdata),
		.scr_req    (scr_req),
		.scr_rdata  (scr_rdata)
	);

	// Main memory: pages 1 to 5, including the status and counter bytes.
	bmce_ram #(
		.WIDTH (8),
		.DEPTH (MEM_BYTES)
	) u_main_ram (
		.clk   (clk),
		.we    (main_req.we),
		.waddr (main_req.waddr),
		.wdata (main_req.wdata),
		.re    (main_req.re),
		.raddr (main_req.raddr),
		.rdata (main_rdata)
	);

	// Scratchpad: pages 1 to 3.
	bmce_ram #(
		.WIDTH (8),
		.DEPTH (SCRATCH_BYTES)
	) u_scr_ram (
		.clk   (clk),
		.we    (scr_req.we),
		.waddr (scr_req.waddr),
		.wdata (scr_req.wdata),
		.re    (scr_req.re),
		.raddr (scr_req.raddr),
		.rdata (scr_rdata)
	);

	// Output register. It takes a new result when it is empty or when its
	// current beat leaves in this cycle, so the engine can start the next
	// input beat while a result still waits downstream.
	logic out_valid_q;

	assign res_take  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			out_data <= res;
		end
	end

endmodule

FILE: rtl/core/bmce_ram.sv
// ----------------------------------------------------------------------------
// bmce_ram
// Generic one-write, one-read synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module bmce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/core/bmce_ctrl.sv
// ----------------------------------------------------------------------------
// bmce_ctrl
// Transaction sequencer: decodes one bus event at a time and drives the
// memory traffic, including read-modify-writes, and the scratchpad traffic.
// ----------------------------------------------------------------------------
`include "battery_monitor_command_engine_unit_macros.svh"

module bmce_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  bmce_pkg::in_item_t  in_data,
	input  bmce_pkg::cfg_t      cfg,
	output logic                res_valid,
	input  logic                res_take,
	output bmce_pkg::out_item_t res,
	output bmce_pkg::main_req_t main_req,
	input  logic [7:0]          main_rdata,
	output bmce_pkg::scr_req_t  scr_req,
	input  logic [7:0]          scr_rdata
);

	import bmce_pkg::*;

	state_t   state_q, state_d;
	phase_t   phase_q, phase_d;
	rmw_op_t  op_q, op_d;
	in_item_t item_q;

	logic [7:0]       cmd_q, cmd_d;
	logic [7:0]       ptr_q, ptr_d;
	logic [15:0]      nv_cd_q, nv_cd_d;
	logic [15:0]      tmp_cd_q, tmp_cd_d;
	logic             tmp_pend_q, tmp_pend_d;
	logic [7:0]       rbyte_q, rbyte_d;
	logic             rvalid_q, rvalid_d;
	logic             err_q, err_d;
	logic [7:0]       base_q, base_d;
	logic             to_mem_q, to_mem_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [7:0]       wr2_addr_q, wr2_addr_d;
	logic [7:0]       wr2_data_q, wr2_data_d;
	logic             rd_main_q, rd_main_d;

	// An entry that was never written still reads as 0xFF.
	logic [MEM_BYTES-1:0]     main_vld_q;
	logic [SCRATCH_BYTES-1:0] scr_vld_q;
	logic                     main_rvld_q;
	logic                     scr_rvld_q;
	logic [7:0]               main_rbyte;
	logic [7:0]               scr_rbyte;
	logic [7:0]               copy_rbyte;

	logic [7:0]        ptr_inc;
	logic [7:0]        cp_addr;
	logic [7:0]        cp_prev;
	logic [7:0]        rmw_inc;
	logic signed [7:0] t_clamp;
	logic [7:0]        t_double;

	assign main_rbyte = main_rvld_q ? main_rdata : 8'hFF;
	assign scr_rbyte  = scr_rvld_q ? scr_rdata : 8'hFF;
	assign copy_rbyte = to_mem_q ? scr_rbyte : main_rbyte;
	assign ptr_inc    = ptr_q + 8'd1;
	assign cp_addr    = base_q + 8'(cnt_q);
	assign cp_prev    = cp_addr - 8'd1;
	assign rmw_inc    = main_rbyte + 8'd1;

	always_comb begin
		t_clamp = item_q.temperature;
		if (t_clamp > TEMP_MAX) begin
			t_clamp = TEMP_MAX;
		end
		if (t_clamp < TEMP_MIN) begin
			t_clamp = TEMP_MIN;
		end
		t_double = t_clamp[7] ? 8'h00 : {t_clamp[6:0], 1'b0};
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign res_valid = (state_q == ST_FINISH);
	assign res       = '{read_byte: rbyte_q, read_valid: rvalid_q,
		command_error: err_q, temp_requested: tmp_pend_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		phase_d    = phase_q;
		op_d       = op_q;
		cmd_d      = cmd_q;
		ptr_d      = ptr_q;
		nv_cd_d    = nv_cd_q;
		tmp_cd_d   = tmp_cd_q;
		tmp_pend_d = tmp_pend_q;
		rbyte_d    = rbyte_q;
		rvalid_d   = rvalid_q;
		err_d      = err_q;
		base_d     = base_q;
		to_mem_d   = to_mem_q;
		cnt_d      = cnt_q;
		wr2_addr_d = wr2_addr_q;
		wr2_data_d = wr2_data_q;
		rd_main_d  = rd_main_q;
		main_req   = '0;
		scr_req    = '0;

		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end

			ST_EXEC: begin
				rbyte_d  = 8'hFF;
				rvalid_d = 1'b0;
				err_d    = 1'b0;
				state_d  = ST_FINISH;
				case (item_q.func)
					FN_BUS_RESET: begin
						phase_d = PH_CMD;
						cmd_d   = 8'h00;
						ptr_d   = 8'h00;
					end

					FN_WRITE: begin
						case (phase_q)
							PH_CMD: begin
								cmd_d   = item_q.data_byte;
								phase_d = PH_DONE;
								case (item_q.data_byte)
									CMD_RD_SCR, CMD_WR_SCR, CMD_RD_MEM: begin
										phase_d = PH_ADDR;
									end
									CMD_COPY1: begin
										main_req.re    = 1'b1;
										main_req.raddr = MAIN_AW'(STATUS_ADDR);
										state_d        = ST_LOCKCHK;
									end
									CMD_COPY2, CMD_COPY3: begin
										if (item_q.data_byte == CMD_COPY2) begin
											nv_cd_d = cfg.nv_busy_ms;
											base_d  = 8'(PAGE_BYTES);
										end else begin
											base_d  = 8'(2 * PAGE_BYTES);
										end
										to_mem_d = 1'b1;
										cnt_d    = '0;
										state_d  = ST_COPY;
									end
									CMD_RECALL1, CMD_RECALL2, CMD_RECALL3: begin
										if (item_q.data_byte == CMD_RECALL1) begin
											base_d  = 8'h00;
										end else if (item_q.data_byte == CMD_RECALL2) begin
											nv_cd_d = cfg.nv_busy_ms;
											base_d  = 8'(PAGE_BYTES);
										end else begin
											nv_cd_d = cfg.nv_busy_ms;
											base_d  = 8'(2 * PAGE_BYTES);
										end
										to_mem_d = 1'b0;
										cnt_d    = '0;
										state_d  = ST_COPY;
									end
									CMD_SET_LCK, CMD_CLR_LCK: begin
										nv_cd_d        = cfg.nv_busy_ms;
										main_req.re    = 1'b1;
										main_req.raddr = MAIN_AW'(STATUS_ADDR);
										op_d           = (item_q.data_byte == CMD_SET_LCK) ?
											RMW_SET_LOCK : RMW_CLR_LOCK;
										state_d        = ST_RMW;
									end
									CMD_TEMP: begin
										tmp_pend_d = 1'b1;
										tmp_cd_d   = cfg.temp_busy_ms;
									end
									CMD_INC_CYC: begin
										nv_cd_d        = cfg.nv_busy_ms;
										main_req.re    = 1'b1;
										main_req.raddr = MAIN_AW'(CYC_LO_ADDR);
										op_d           = RMW_INC_LO;
										state_d        = ST_RMW;
									end
									CMD_CLR_CYC: begin
										nv_cd_d        = cfg.nv_busy_ms;
										main_req.we    = 1'b1;
										main_req.waddr = MAIN_AW'(CYC_HI_ADDR);
										main_req.wdata = 8'h00;
										wr2_addr_d     = CYC_LO_ADDR;
										wr2_data_d     = 8'h00;
										state_d        = ST_WR2;
									end
									CMD_NOP: begin
									end
									CMD_DATA: begin
										phase_d = PH_DATA;
									end
									default: begin
										err_d = 1'b1;
									end
								endcase
							end

							PH_ADDR: begin
								ptr_d   = item_q.data_byte;
								phase_d = PH_DONE;
								if (cmd_q == CMD_RD_SCR || cmd_q == CMD_WR_SCR) begin
									if (item_q.data_byte < 8'(SCRATCH_BYTES)) begin
										phase_d = (cmd_q == CMD_RD_SCR) ? PH_RD_SCR : PH_WR_SCR;
									end
								end else if (cmd_q == CMD_RD_MEM &&
									item_q.data_byte >= 8'(MEM_READ_START) &&
									item_q.data_byte < 8'(MEM_READ_END)) begin
									phase_d        = PH_RD_MEM;
									main_req.re    = 1'b1;
									main_req.raddr = MAIN_AW'(STATUS_ADDR);
									op_d           = RMW_STATUS;
									state_d        = ST_RMW;
								end
							end

							PH_WR_SCR: begin
								scr_req.we    = 1'b1;
								scr_req.waddr = ptr_q[SCR_AW-1:0];
								scr_req.wdata = item_q.data_byte;
								ptr_d         = ptr_inc;
								if (ptr_inc >= 8'(SCRATCH_BYTES)) begin
									phase_d = PH_DONE;
								end
							end

							PH_DATA: begin
								phase_d = PH_DONE;
							end

							default: begin
							end
						endcase
					end

					FN_READ: begin
						if (phase_q == PH_RD_SCR) begin
							scr_req.re    = 1'b1;
							scr_req.raddr = ptr_q[SCR_AW-1:0];
							rd_main_d     = 1'b0;
							state_d       = ST_RDWAIT;
							ptr_d         = ptr_inc;
							if (ptr_inc >= 8'(SCRATCH_BYTES)) begin
								phase_d = PH_DONE;
							end
						end else if (phase_q == PH_RD_MEM) begin
							ptr_d = ptr_inc;
							if (ptr_inc >= 8'(MEM_READ_END)) begin
								phase_d = PH_DONE;
							end
							if (ptr_q == ID_LO_ADDR) begin
								rbyte_d  = cfg.device_id[7:0];
								rvalid_d = 1'b1;
							end else if (ptr_q == ID_HI_ADDR) begin
								rbyte_d  = cfg.device_id[15:8];
								rvalid_d = 1'b1;
							end else begin
								main_req.re    = 1'b1;
								main_req.raddr = MAIN_AW'(ptr_q);
								rd_main_d      = 1'b1;
								state_d        = ST_RDWAIT;
							end
						end
					end

					FN_TICK: begin
						if (nv_cd_q != 16'd0) begin
							nv_cd_d = nv_cd_q - 16'd1;
						end
						if (tmp_cd_q != 16'd0) begin
							tmp_cd_d = tmp_cd_q - 16'd1;
						end
					end

					FN_SET_TEMP: begin
						main_req.we    = 1'b1;
						main_req.waddr = MAIN_AW'(TEMP_ADDR);
						main_req.wdata = t_clamp;
						wr2_addr_d     = TEMP2_ADDR;
						wr2_data_d     = t_double;
						tmp_pend_d     = 1'b0;
						state_d        = ST_WR2;
					end

					FN_PRESET: begin
						main_req.we    = 1'b1;
						main_req.waddr = MAIN_AW'(CYC_HI_ADDR);
						main_req.wdata = item_q.cycle_preset[15:8];
						wr2_addr_d     = CYC_LO_ADDR;
						wr2_data_d     = item_q.cycle_preset[7:0];
						state_d        = ST_WR2;
					end

					default: begin
					end
				endcase
			end

			ST_LOCKCHK: begin
				if (main_rbyte[LOCK_BIT]) begin
					state_d = ST_FINISH;
				end else begin
					nv_cd_d  = cfg.nv_busy_ms;
					base_d   = 8'h00;
					to_mem_d = 1'b1;
					cnt_d    = '0;
					state_d  = ST_COPY;
				end
			end

			// Source read of entry n overlaps the destination write of entry n-1.
			ST_COPY: begin
				if (cnt_q < CNT_W'(PAGE_BYTES)) begin
					if (to_mem_q) begin
						scr_req.re    = 1'b1;
						scr_req.raddr = cp_addr[SCR_AW-1:0];
					end else begin
						main_req.re    = 1'b1;
						main_req.raddr = MAIN_AW'(cp_addr);
					end
				end
				if (cnt_q != '0) begin
					if (to_mem_q) begin
						main_req.we    = 1'b1;
						main_req.waddr = MAIN_AW'(cp_prev);
						main_req.wdata = copy_rbyte;
					end else begin
						scr_req.we    = 1'b1;
						scr_req.waddr = cp_prev[SCR_AW-1:0];
						scr_req.wdata = copy_rbyte;
					end
				end
				cnt_d = cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(PAGE_BYTES)) begin
					state_d = ST_FINISH;
				end
			end

			ST_RMW: begin
				state_d     = ST_FINISH;
				main_req.we = 1'b1;
				case (op_q)
					RMW_SET_LOCK: begin
						main_req.waddr = MAIN_AW'(STATUS_ADDR);
						main_req.wdata = main_rbyte | LOCK_MASK;
					end
					RMW_CLR_LOCK: begin
						main_req.waddr = MAIN_AW'(STATUS_ADDR);
						main_req.wdata = main_rbyte & ~LOCK_MASK;
					end
					RMW_STATUS: begin
						main_req.waddr = MAIN_AW'(STATUS_ADDR);
						main_req.wdata = {main_rbyte[7:2], nv_cd_q != 16'd0, tmp_cd_q != 16'd0};
					end
					RMW_INC_LO: begin
						main_req.waddr = MAIN_AW'(CYC_LO_ADDR);
						main_req.wdata = rmw_inc;
						// Carry into the high byte takes one more read.
						if (rmw_inc == 8'h00) begin
							main_req.re    = 1'b1;
							main_req.raddr = MAIN_AW'(CYC_HI_ADDR);
							op_d           = RMW_INC_HI;
							state_d        = ST_RMW;
						end
					end
					RMW_INC_HI: begin
						main_req.waddr = MAIN_AW'(CYC_HI_ADDR);
						main_req.wdata = rmw_inc;
					end
					default: begin
						main_req.we = 1'b0;
					end
				endcase
			end

			ST_WR2: begin
				main_req.we    = 1'b1;
				main_req.waddr = MAIN_AW'(wr2_addr_q);
				main_req.wdata = wr2_data_q;
				state_d        = ST_FINISH;
			end

			ST_RDWAIT: begin
				rbyte_d  = rd_main_q ? main_rbyte : scr_rbyte;
				rvalid_d = 1'b1;
				state_d  = ST_FINISH;
			end

			ST_FINISH: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_CMD;
			cmd_q       <= 8'h00;
			ptr_q       <= 8'h00;
			nv_cd_q     <= 16'd0;
			tmp_cd_q    <= 16'd0;
			tmp_pend_q  <= 1'b0;
			main_vld_q  <= '0;
			scr_vld_q   <= '0;
		end else begin
			phase_q    <= phase_d;
			cmd_q      <= cmd_d;
			ptr_q      <= ptr_d;
			nv_cd_q    <= nv_cd_d;
			tmp_cd_q   <= tmp_cd_d;
			tmp_pend_q <= tmp_pend_d;
			if (main_req.we) begin
				main_vld_q[main_req.waddr] <= 1'b1;
			end
			if (scr_req.we) begin
				scr_vld_q[scr_req.waddr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			item_q <= in_data;
		end
		if (main_req.re) begin
			main_rvld_q <= main_vld_q[main_req.raddr];
		end
		if (scr_req.re) begin
			scr_rvld_q <= scr_vld_q[scr_req.raddr];
		end
		op_q       <= op_d;
		rbyte_q    <= rbyte_d;
		rvalid_q   <= rvalid_d;
		err_q      <= err_d;
		base_q     <= base_d;
		to_mem_q   <= to_mem_d;
		cnt_q      <= cnt_d;
		wr2_addr_q <= wr2_addr_d;
		wr2_data_q <= wr2_data_d;
		rd_main_q  <= rd_main_d;
	end

	`BMCE_ASSERT_IMP(a_main_rw_apart, main_req.we && main_req.re, main_req.waddr != main_req.raddr)
	`BMCE_ASSERT_IMP(a_scr_rw_apart, scr_req.we && scr_req.re, scr_req.waddr != scr_req.raddr)
	`BMCE_ASSERT_IMP(a_scr_stream_ptr, phase_q == PH_RD_SCR || phase_q == PH_WR_SCR, ptr_q < 8'(SCRATCH_BYTES))
	`BMCE_ASSERT_IMP(a_mem_stream_ptr, phase_q == PH_RD_MEM, ptr_q >= 8'(MEM_READ_START) && ptr_q < 8'(MEM_READ_END))
	`BMCE_ASSERT_NXT(a_copy_ends, state_q == ST_COPY && cnt_q == CNT_W'(PAGE_BYTES), state_q == ST_FINISH)

endmodule
